/* design/safeguarded_newton_root_search_macros.svh */
// Assertion macros for the file that checks its own logic.
`ifndef SAFEGUARDED_NEWTON_ROOT_SEARCH_MACROS_SVH
`define SAFEGUARDED_NEWTON_ROOT_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SNRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/snrs_pkg.sv */
package snrs_pkg;

    localparam int TOL_BITS  = 31;
    localparam int ITER_BITS = 8;
    localparam int IDX_BITS  = 2;
    localparam int CFG_BITS  = 32;

    localparam logic [IDX_BITS-1:0] CFG_TOLERANCE      = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_MAX_ITERATIONS = 2'd1;

    localparam logic [TOL_BITS-1:0]  TOL_RESET  = 31'd66;
    localparam logic [ITER_BITS-1:0] ITER_RESET = 8'd100;

    localparam logic OP_START = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    typedef enum logic [1:0] {
        KIND_EVAL   = 2'd0,
        KIND_ROOT   = 2'd1,
        KIND_FAIL   = 2'd2,
        KIND_UNEXP  = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_END_A = 5'b00010,
        PH_END_B = 5'b00100,
        PH_MID   = 5'b01000,
        PH_LOOP  = 5'b10000
    } phase_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL_H  = 6'b000010,
        S_MUL_L  = 6'b000100,
        S_MUL_S  = 6'b001000,
        S_DECIDE = 6'b010000,
        S_DIV    = 6'b100000
    } seq_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

/* design/snrs_if.sv */
interface snrs_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic                op;
    logic signed [W-1:0] point_a;
    logic signed [W-1:0] point_b;
    logic signed [W-1:0] f_value;
    logic signed [W-1:0] df_value;
    modport source (output valid, op, point_a, point_b, f_value, df_value, input ready);
    modport sink (input valid, op, point_a, point_b, f_value, df_value, output ready);
endinterface

interface snrs_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic signed [W-1:0] point;
    logic                bracket_bad;
    modport source (output valid, kind, point, bracket_bad, input ready);
    modport sink (input valid, kind, point, bracket_bad, output ready);
endinterface

interface snrs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [snrs_pkg::IDX_BITS-1:0]  index;
    logic [snrs_pkg::CFG_BITS-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/snrs_divider.sv */
module snrs_divider #(
    parameter int DIVIDEND_BITS = 48,
    parameter int DIVISOR_BITS  = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);
    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] dvd_reg;
    logic [DIVISOR_BITS-1:0]  dvs_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    // One quotient bit per cycle, most significant first, restoring form.
    assign trial = {rem_reg, dvd_reg[DIVIDEND_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = !diff[DIVISOR_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIVIDEND_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            dvd_reg <= {dvd_reg[DIVIDEND_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;
endmodule

/* design/safeguarded_newton_root_search.sv */
// Safeguarded Newton root search with a bisection fallback, in signed fixed point.
// The cmd channel takes requests: op start carries the two bracket ends, op reply
// carries f and f' at the point last asked for. Every request yields exactly one
// item on the res channel: a point to evaluate, the root, an iteration limit
// failure or an unexpected reply flag. The cfg channel writes the tolerance and
// the iteration limit and is always ready.
// A start, a reply for either bracket end, a failure or an unexpected reply is
// written straight into the result register. A reply for the midpoint or in the
// loop runs through a shared multiplier for three products and a decision step,
// which writes the result for a bisection step; a Newton step then also waits
// for the bit-serial divider.
// The block takes one request at a time and is not ready while it is working or
// while a result waits in the result register; a stalled receiver therefore holds
// off the next request. Reset clears the search to idle and loads the default
// tolerance and iteration limit.
`include "safeguarded_newton_root_search_macros.svh"

module safeguarded_newton_root_search #(
    parameter int VALUE_BITS    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    snrs_cfg_if.sink    cfg,
    snrs_in_if.sink     cmd,
    snrs_out_if.source  res
);
    localparam int W  = VALUE_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int PW = 2 * W + 2;
    localparam int DW = W + FB;
    localparam int TW = W + snrs_pkg::TOL_BITS;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    snrs_pkg::phase_t phase_reg;
    snrs_pkg::seq_t   state_reg;

    logic [snrs_pkg::TOL_BITS-1:0]  tol_reg;
    logic [snrs_pkg::ITER_BITS-1:0] max_iter_reg;
    logic [snrs_pkg::ITER_BITS-1:0] iter_reg;
    logic signed [W-1:0] lo_end_reg, hi_end_reg, f_first_reg;
    logic signed [W-1:0] neg_side_reg, pos_side_reg, est_reg;
    logic signed [W-1:0] last_step_reg, older_step_reg;
    logic signed [W-1:0] f_reg, df_reg;
    logic                warn_reg;
    logic signed [PW-1:0] prod_reg;
    logic                h_zero_reg, h_neg_reg, l_zero_reg, l_neg_reg;

    logic                out_valid_reg;
    logic [1:0]          out_kind_reg;
    logic signed [W-1:0] out_point_reg;
    logic                out_bad_reg;

    logic                in_acc;
    logic                cfg_acc;
    logic signed [W:0]   dxh, dxl, span, ab_sum, ab_diff, nwt_diff;
    logic [W:0]          ab_mag;
    logic signed [W:0]   mul_a, mul_b;
    logic signed [PW-1:0] fs_wide, cmp_diff, slow_lhs;
    logic [W-1:0]        f_mag, df_mag, older_mag, step_mag;
    logic                outside, slow, bisect;
    logic signed [W-1:0] bis_step, bis_est;
    logic signed [W-1:0] q_sat, nwt_est;
    logic                q_neg;
    logic [DW-1:0]       q_mag;
    logic signed [W-1:0] new_step, new_est, base_pt;
    logic                finish, is_root;
    logic [snrs_pkg::ITER_BITS-1:0] limit, iter_inc;
    logic                warn_now, f_neg;
    snrs_pkg::div_ctrl_t div_ctrl;

    assign in_acc    = cmd.valid && cmd.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign cmd.ready = (state_reg == snrs_pkg::S_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;

    assign res.valid       = out_valid_reg;
    assign res.kind        = out_kind_reg;
    assign res.point       = out_point_reg;
    assign res.bracket_bad = out_bad_reg;

    assign f_mag     = f_reg[W-1] ? W'(-f_reg) : W'(f_reg);
    assign df_mag    = df_reg[W-1] ? W'(-df_reg) : W'(df_reg);
    assign older_mag = older_step_reg[W-1] ? W'(-older_step_reg) : W'(older_step_reg);

    assign dxh  = {est_reg[W-1], est_reg} - {pos_side_reg[W-1], pos_side_reg};
    assign dxl  = {est_reg[W-1], est_reg} - {neg_side_reg[W-1], neg_side_reg};
    assign span = {pos_side_reg[W-1], pos_side_reg} - {neg_side_reg[W-1], neg_side_reg};

    always_comb
    begin
        mul_a = dxh;
        mul_b = {df_reg[W-1], df_reg};
        case (state_reg)
            snrs_pkg::S_MUL_L: mul_a = dxl;
            snrs_pkg::S_MUL_S:
            begin
                mul_a = {1'b0, older_mag};
                mul_b = {1'b0, df_mag};
            end
            default: mul_a = dxh;
        endcase
    end

    assign fs_wide  = {{(PW-DW){f_reg[W-1]}}, f_reg, {FB{1'b0}}};
    assign cmp_diff = prod_reg - fs_wide;
    assign slow_lhs = PW'({f_mag, {(FB+1){1'b0}}});
    assign slow     = $unsigned(slow_lhs) > $unsigned(prod_reg);
    assign outside  = h_zero_reg || l_zero_reg || (h_neg_reg == l_neg_reg);
    assign bisect   = outside || slow;

    assign bis_step = span[W:1];
    assign bis_est  = neg_side_reg + bis_step;

    assign q_neg = f_reg[W-1] != df_reg[W-1];
    always_comb
    begin
        if (!q_neg)
            q_sat = (q_mag > DW'(VMAX)) ? VMAX : W'(q_mag);
        else
            q_sat = (q_mag > DW'({1'b1, {(W-1){1'b0}}})) ? VMIN : W'(-q_mag);
    end
    assign nwt_diff = {est_reg[W-1], est_reg} - {q_sat[W-1], q_sat};
    always_comb
    begin
        if (nwt_diff[W] != nwt_diff[W-1])
            nwt_est = nwt_diff[W] ? VMIN : VMAX;
        else
            nwt_est = nwt_diff[W-1:0];
    end

    assign new_step = (state_reg == snrs_pkg::S_DECIDE) ? bis_step : q_sat;
    assign new_est  = (state_reg == snrs_pkg::S_DECIDE) ? bis_est : nwt_est;
    assign base_pt  = (state_reg == snrs_pkg::S_DECIDE) ? neg_side_reg : est_reg;
    assign step_mag = new_step[W-1] ? W'(-new_step) : W'(new_step);
    assign is_root  = (new_est == base_pt) || (TW'(step_mag) < TW'(tol_reg));
    assign finish   = ((state_reg == snrs_pkg::S_DECIDE) && bisect)
                   || ((state_reg == snrs_pkg::S_DIV) && div_ctrl.done);

    assign div_ctrl.start = (state_reg == snrs_pkg::S_DECIDE) && !bisect;

    snrs_divider #(
        .DIVIDEND_BITS(DW),
        .DIVISOR_BITS(W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctrl.start),
        .dividend ({f_mag, {FB{1'b0}}}),
        .divisor  (df_mag),
        .done     (div_ctrl.done),
        .quotient (q_mag)
    );

    assign ab_sum   = {lo_end_reg[W-1], lo_end_reg} + {hi_end_reg[W-1], hi_end_reg};
    assign ab_diff  = {lo_end_reg[W-1], lo_end_reg} - {hi_end_reg[W-1], hi_end_reg};
    assign ab_mag   = ab_diff[W] ? (W+1)'(-ab_diff) : (W+1)'(ab_diff);
    assign f_neg    = cmd.f_value[W-1];
    assign warn_now = ((f_first_reg > 0) && (cmd.f_value > 0))
                   || (f_first_reg[W-1] && f_neg);
    assign limit    = (max_iter_reg == '0) ? snrs_pkg::ITER_BITS'(1) : max_iter_reg;
    assign iter_inc = iter_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg        <= snrs_pkg::TOL_RESET;
            max_iter_reg   <= snrs_pkg::ITER_RESET;
            phase_reg      <= snrs_pkg::PH_IDLE;
            state_reg      <= snrs_pkg::S_IDLE;
            iter_reg       <= '0;
            warn_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            lo_end_reg     <= '0;
            hi_end_reg     <= '0;
            f_first_reg    <= '0;
            neg_side_reg   <= '0;
            pos_side_reg   <= '0;
            est_reg        <= '0;
            last_step_reg  <= '0;
            older_step_reg <= '0;
        end
        else
        begin
            if (cfg_acc)
            begin
                unique case (cfg.index)
                    snrs_pkg::CFG_TOLERANCE:
                        tol_reg <= cfg.data[snrs_pkg::TOL_BITS-1:0];
                    snrs_pkg::CFG_MAX_ITERATIONS:
                        max_iter_reg <= cfg.data[snrs_pkg::ITER_BITS-1:0];
                    default: ;
                endcase
            end

            if (res.ready)
                out_valid_reg <= 1'b0;

            if (in_acc)
            begin
                if (cmd.op == snrs_pkg::OP_START)
                begin
                    lo_end_reg    <= cmd.point_a;
                    hi_end_reg    <= cmd.point_b;
                    warn_reg      <= 1'b0;
                    iter_reg      <= '0;
                    phase_reg     <= snrs_pkg::PH_END_A;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                    unique case (phase_reg)
                        snrs_pkg::PH_END_A:
                        begin
                            f_first_reg <= cmd.f_value;
                            phase_reg   <= snrs_pkg::PH_END_B;
                        end
                        snrs_pkg::PH_END_B:
                        begin
                            warn_reg <= warn_now;
                            if ((f_first_reg == '0) || (cmd.f_value == '0))
                                phase_reg <= snrs_pkg::PH_IDLE;
                            else
                            begin
                                neg_side_reg   <= f_first_reg[W-1] ? lo_end_reg : hi_end_reg;
                                pos_side_reg   <= f_first_reg[W-1] ? hi_end_reg : lo_end_reg;
                                est_reg        <= ab_sum[W:1];
                                older_step_reg <= (ab_mag > (W+1)'(VMAX)) ? VMAX : W'(ab_mag);
                                last_step_reg  <= (ab_mag > (W+1)'(VMAX)) ? VMAX : W'(ab_mag);
                                phase_reg      <= snrs_pkg::PH_MID;
                            end
                        end
                        snrs_pkg::PH_MID:
                        begin
                            iter_reg      <= '0;
                            out_valid_reg <= 1'b0;
                            state_reg     <= snrs_pkg::S_MUL_H;
                        end
                        snrs_pkg::PH_LOOP:
                        begin
                            if (f_neg)
                                neg_side_reg <= est_reg;
                            else
                                pos_side_reg <= est_reg;
                            iter_reg <= iter_inc;
                            if (iter_inc >= limit)
                                phase_reg <= snrs_pkg::PH_IDLE;
                            else
                            begin
                                out_valid_reg <= 1'b0;
                                state_reg     <= snrs_pkg::S_MUL_H;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            unique case (state_reg)
                snrs_pkg::S_MUL_H:  state_reg <= snrs_pkg::S_MUL_L;
                snrs_pkg::S_MUL_L:  state_reg <= snrs_pkg::S_MUL_S;
                snrs_pkg::S_MUL_S:  state_reg <= snrs_pkg::S_DECIDE;
                snrs_pkg::S_DECIDE:
                    state_reg <= bisect ? snrs_pkg::S_IDLE : snrs_pkg::S_DIV;
                snrs_pkg::S_DIV:
                    if (div_ctrl.done)
                        state_reg <= snrs_pkg::S_IDLE;
                default: ;
            endcase

            if (finish)
            begin
                older_step_reg <= last_step_reg;
                last_step_reg  <= new_step;
                est_reg        <= new_est;
                out_valid_reg  <= 1'b1;
                phase_reg      <= is_root ? snrs_pkg::PH_IDLE : snrs_pkg::PH_LOOP;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a * mul_b);
        if (state_reg == snrs_pkg::S_MUL_L)
        begin
            h_zero_reg <= (cmp_diff == '0);
            h_neg_reg  <= cmp_diff[PW-1];
        end
        if (state_reg == snrs_pkg::S_MUL_S)
        begin
            l_zero_reg <= (cmp_diff == '0);
            l_neg_reg  <= cmp_diff[PW-1];
        end
        if (in_acc)
        begin
            f_reg  <= cmd.f_value;
            df_reg <= cmd.df_value;
            if (cmd.op == snrs_pkg::OP_START)
            begin
                out_kind_reg  <= snrs_pkg::KIND_EVAL;
                out_point_reg <= cmd.point_a;
                out_bad_reg   <= 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    snrs_pkg::PH_END_A:
                    begin
                        out_kind_reg  <= snrs_pkg::KIND_EVAL;
                        out_point_reg <= hi_end_reg;
                        out_bad_reg   <= 1'b0;
                    end
                    snrs_pkg::PH_END_B:
                    begin
                        out_bad_reg <= warn_now;
                        if (f_first_reg == '0)
                        begin
                            out_kind_reg  <= snrs_pkg::KIND_ROOT;
                            out_point_reg <= lo_end_reg;
                        end
                        else if (cmd.f_value == '0)
                        begin
                            out_kind_reg  <= snrs_pkg::KIND_ROOT;
                            out_point_reg <= hi_end_reg;
                        end
                        else
                        begin
                            out_kind_reg  <= snrs_pkg::KIND_EVAL;
                            out_point_reg <= ab_sum[W:1];
                        end
                    end
                    snrs_pkg::PH_LOOP:
                    begin
                        out_kind_reg  <= snrs_pkg::KIND_FAIL;
                        out_point_reg <= '0;
                        out_bad_reg   <= warn_reg;
                    end
                    snrs_pkg::PH_MID: ;
                    default:
                    begin
                        out_kind_reg  <= snrs_pkg::KIND_UNEXP;
                        out_point_reg <= '0;
                        out_bad_reg   <= 1'b0;
                    end
                endcase
            end
        end
        if (finish)
        begin
            out_kind_reg  <= is_root ? snrs_pkg::KIND_ROOT : snrs_pkg::KIND_EVAL;
            out_point_reg <= new_est;
            out_bad_reg   <= warn_reg;
        end
    end

    `SNRS_ASSERT_NOW(a_busy_not_ready, state_reg != snrs_pkg::S_IDLE, !cmd.ready,
        "request taken while the sequencer is busy")
    `SNRS_ASSERT_NEXT(a_accept_progress, in_acc,
        (state_reg != snrs_pkg::S_IDLE) || out_valid_reg,
        "accepted request neither produced a result nor started work")
    `SNRS_ASSERT_NOW(a_div_start, div_ctrl.start, state_reg == snrs_pkg::S_DECIDE,
        "divider started outside the decision step")
    `SNRS_ASSERT_NOW(a_div_done, div_ctrl.done, state_reg == snrs_pkg::S_DIV,
        "divider finished while no division was awaited")
endmodule
